// ----- rtl/core/spm_pkg.sv -----
// Package for the sorted position table: entry type, codes and cell controls.
`default_nettype none
package spm_pkg;

  // One stored automaton position.
  typedef struct packed {
    logic [15:0] term;
    logic [5:0]  err;
    logic        spec;
  } pos_t;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_DUP      = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_CLEARED  = 3'd3;
  localparam logic [2:0] STAT_DUMP     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_CLR,
    ST_DUMP
  } state_e;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic cap;         // register compare flags against the incoming request
    logic ins_commit;  // open the gap at the boundary and load the new entry
    logic rotate;      // move the valid entries one place toward the head
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/sorted_position_merge.sv -----
// Top level of the sorted position table built as a chain of compare cells.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   func, term_id, error_count, special
//   out      output     out_valid_o / out_stall_i status, entry fields, slot, count, last
//   cfg      input      cfg_valid_i / cfg_ready_o algorithm_mode (cfg_data_i)
//
// An insert or clear first registers every cell's compare flags, then commits the shift
// and loads the output register. A dump of an empty table gives one status result; else it
// gives one entry a cycle while the output is not stalled, as the chain rotates
// toward the head cell.
// Reset empties the table by clearing the entry count; cell contents are not reset.
// A stalled output holds the chain; a request is taken only while the block is idle.
`default_nettype none
module sorted_position_merge
  import spm_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [15:0] term_id_i,
  input  wire logic [5:0]  error_count_i,
  input  wire logic        special_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      entry_term_id_o,
  output logic [5:0]       entry_error_count_o,
  output logic             entry_special_o,
  output logic             entry_valid_o,
  output logic [5:0]       slot_o,
  output logic [5:0]       count_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_data_i
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  function automatic logic [5:0] to6(input logic [CW-1:0] x);
    logic [CW+5:0] t;
    t = {6'b0, x};
    return t[5:0];
  endfunction

  state_e          state_q, state_d;
  logic [1:0]      mode_q;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  pos_t            req_q;
  pos_t            cmp;
  logic            use_sp;
  logic            in_acc;
  logic            out_load;
  cell_ctrl_t      ctrl;

  logic            out_valid_q, out_valid_d;
  logic [2:0]      status_q, status_d;
  pos_t            oent_q, oent_d;
  logic            ovalid_q, ovalid_d;
  logic [5:0]      slot_q, slot_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            last_q, last_d;
  logic            res;

  pos_t            ent   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] after, bnd, eq, valid;
  logic [IW-1:0]   enc;
  logic [CW-1:0]   pos;
  logic            dup, full;

  assign use_sp      = |mode_q;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cmp.term = term_id_i;
    cmp.err  = error_count_i;
    cmp.spec = special_i && use_sp;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      assign valid[g] = (count_q > CW'(g));
      if (g == 0) begin : g_head
        spm_cell u_cell (
          .clk_i, .rst_ni, .ctrl_i(ctrl), .use_sp_i(use_sp), .cmp_i(cmp),
          .new_i(req_q), .valid_i(valid[g]), .next_valid_i(valid[g+1]),
          .prev_after_i(1'b1), .prev_i(req_q), .next_i(ent[g+1]), .head_i(ent[0]),
          .ent_o(ent[g]), .after_o(after[g]), .bnd_o(bnd[g]), .eq_o(eq[g])
        );
      end else if (g == TABLE_DEPTH - 1) begin : g_tail
        spm_cell u_cell (
          .clk_i, .rst_ni, .ctrl_i(ctrl), .use_sp_i(use_sp), .cmp_i(cmp),
          .new_i(req_q), .valid_i(valid[g]), .next_valid_i(1'b0),
          .prev_after_i(after[g-1]), .prev_i(ent[g-1]), .next_i(ent[0]),
          .head_i(ent[0]),
          .ent_o(ent[g]), .after_o(after[g]), .bnd_o(bnd[g]), .eq_o(eq[g])
        );
      end else begin : g_mid
        spm_cell u_cell (
          .clk_i, .rst_ni, .ctrl_i(ctrl), .use_sp_i(use_sp), .cmp_i(cmp),
          .new_i(req_q), .valid_i(valid[g]), .next_valid_i(valid[g+1]),
          .prev_after_i(after[g-1]), .prev_i(ent[g-1]), .next_i(ent[g+1]),
          .head_i(ent[0]),
          .ent_o(ent[g]), .after_o(after[g]), .bnd_o(bnd[g]), .eq_o(eq[g])
        );
      end
    end
  endgenerate

  // The boundary is one-hot, or absent when the new entry goes after every cell.
  always_comb begin
    enc = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (bnd[k]) begin
        enc = enc | IW'(k);
      end
    end
    pos  = after[TABLE_DEPTH-1] ? CW'(TABLE_DEPTH) : CW'(enc);
    dup  = |(bnd & eq);
    full = (count_q == CW'(TABLE_DEPTH));
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    ctrl       = '0;
    res        = 1'b0;
    status_d   = status_q;
    oent_d     = '0;
    ovalid_d   = 1'b0;
    slot_d     = slot_q;
    cnt_d      = cnt_q;
    last_d     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.cap = 1'b1;
          unique case (func_i)
            FUNC_INSERT: state_d = ST_INS;
            FUNC_CLEAR:  state_d = ST_CLR;
            FUNC_DUMP:   state_d = ST_DUMP;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS: begin
        if (out_load) begin
          res     = 1'b1;
          slot_d  = to6(pos);
          cnt_d   = to6(count_q);
          state_d = ST_IDLE;
          if (dup) begin
            status_d = STAT_DUP;
          end else if (full) begin
            status_d = STAT_FULL;
          end else begin
            status_d        = STAT_INSERTED;
            ctrl.ins_commit = 1'b1;
            count_d         = count_q + CW'(1);
            cnt_d           = to6(count_q + CW'(1));
          end
        end
      end
      ST_CLR: begin
        if (out_load) begin
          res      = 1'b1;
          status_d = STAT_CLEARED;
          slot_d   = '0;
          cnt_d    = '0;
          count_d  = '0;
          state_d  = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_load) begin
          res      = 1'b1;
          status_d = STAT_DUMP;
          cnt_d    = to6(count_q);
          if (count_q == '0) begin
            slot_d  = '0;
            state_d = ST_IDLE;
          end else begin
            oent_d      = ent[0];
            ovalid_d    = 1'b1;
            slot_d      = to6(idx_q);
            last_d      = (idx_q == count_q - CW'(1));
            ctrl.rotate = 1'b1;
            if (last_d) begin
              idx_d   = '0;
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + CW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= cmp;
    end
    if (res) begin
      status_q <= status_d;
      oent_q   <= oent_d;
      ovalid_q <= ovalid_d;
      slot_q   <= slot_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign entry_term_id_o     = oent_q.term;
  assign entry_error_count_o = oent_q.err;
  assign entry_special_o     = oent_q.spec;
  assign entry_valid_o       = ovalid_q;
  assign slot_o              = slot_q;
  assign count_o             = cnt_q;
  assign last_o              = last_q;

endmodule
`default_nettype wire

// ----- rtl/core/spm_cell.sv -----
// One cell of the position chain: holds one entry and its compare flags.
`default_nettype none
module spm_cell
  import spm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       use_sp_i,
  input  wire pos_t       cmp_i,
  input  wire pos_t       new_i,
  input  wire logic       valid_i,
  input  wire logic       next_valid_i,
  input  wire logic       prev_after_i,
  input  wire pos_t       prev_i,
  input  wire pos_t       next_i,
  input  wire pos_t       head_i,
  output pos_t            ent_o,
  output logic            after_o,
  output logic            bnd_o,
  output logic            eq_o
);

  pos_t ent_q, ent_d;
  logic after_q, after_d;
  logic eq_q, eq_d;
  logic goes_after;
  logic same;

  always_comb begin
    goes_after = 1'b0;
    if (cmp_i.err < ent_q.err) begin
      goes_after = 1'b1;
    end else if (cmp_i.err == ent_q.err) begin
      goes_after = (cmp_i.term < ent_q.term) ||
                   (use_sp_i && (cmp_i.term == ent_q.term) && !cmp_i.spec && ent_q.spec);
    end
    same = (cmp_i.term == ent_q.term) && (cmp_i.err == ent_q.err) &&
           (!use_sp_i || (cmp_i.spec == ent_q.spec));
  end

  always_comb begin
    after_d = after_q;
    eq_d    = eq_q;
    if (ctrl_i.cap) begin
      after_d = valid_i && goes_after;
      eq_d    = valid_i && same;
    end
  end

  // The boundary cell is the first one that the new entry does not go after.
  assign bnd_o   = prev_after_i && !after_q;
  assign after_o = after_q;
  assign eq_o    = eq_q;
  assign ent_o   = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.ins_commit) begin
      if (after_q) begin
        ent_d = ent_q;
      end else if (bnd_o) begin
        ent_d = new_i;
      end else begin
        ent_d = prev_i;
      end
    end else if (ctrl_i.rotate) begin
      // The last valid cell takes the head, so a full pass restores the order.
      if (next_valid_i) begin
        ent_d = next_i;
      end else if (valid_i) begin
        ent_d = head_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_q <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      after_q <= after_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule
`default_nettype wire
